/* hdl/ddays_pkg.sv */
// Shared types, constants and calendar tables for the date difference block.
// Used by the lane, the merge stage and the top level; depends on nothing.
package ddays_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W = 5;
  localparam int unsigned NUM_W = 22;
  localparam int unsigned DIFF_W = 23;
  localparam int unsigned PROD_W = 27;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic s1;
    logic s2;
  } ddays_en_t;

  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] num;
  } ddays_lane_t;

  // Days in the months before month m of a common year.
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month m; zero for a month code that names no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:                          r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:       r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                  r = 5'd31;
      default:                       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/date_difference_in_days.sv */
// Throughput: one pair of dates per cycle unless the output holds back; the two lane
// register stages and the merge output register form a three-deep pipeline that
// stalls only when it is full and the output is held.
// Reset clears the stage valid bits only; the data registers are not reset.
// Top level of the date difference block; depends on ddays_pkg, ddays_lane, ddays_merge.
module date_difference_in_days
  import ddays_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0 up: first_year[13:0], first_month[17:14], first_day[22:18],
  // second_year[36:23], second_month[40:37], second_day[45:41],
  // include_end_day[46], zero fill[47].
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0 up: day_difference[22:0] (signed), date_error[23].
  output logic [23:0] m_axis_tdata_o
);

  // One valid bit per pipeline stage. A stage takes new data when it is
  // empty or when the stage after it is taking its data, so bubbles close
  // up and a new transfer is accepted while a result waits at the output.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic inc1_q, inc2_q;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // The end-day flag rides alongside the lanes to the merge stage.
  always_ff @(posedge clk_i) begin
    if (rdy1) inc1_q <= s_axis_tdata_i[46];
    if (rdy2) inc2_q <= inc1_q;
  end

  ddays_en_t   lane_en;
  ddays_lane_t first_res, second_res;

  assign lane_en.s1 = rdy1;
  assign lane_en.s2 = rdy2;

  // Each lane converts one of the two dates to a day number.
  ddays_lane u_lane_first (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .year_i  (s_axis_tdata_i[13:0]),
    .month_i (s_axis_tdata_i[17:14]),
    .day_i   (s_axis_tdata_i[22:18]),
    .res_o   (first_res)
  );

  ddays_lane u_lane_second (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .year_i  (s_axis_tdata_i[36:23]),
    .month_i (s_axis_tdata_i[40:37]),
    .day_i   (s_axis_tdata_i[45:41]),
    .res_o   (second_res)
  );

  logic [DIFF_W-1:0] diff;
  logic              err;

  // The merge stage combines the lanes and owns the output register.
  ddays_merge u_merge (
    .clk_i    (clk_i),
    .load_i   (rdy3),
    .first_i  (first_res),
    .second_i (second_res),
    .inc_i    (inc2_q),
    .diff_o   (diff),
    .err_o    (err)
  );

  assign m_axis_tdata_o = {err, diff};

`ifndef SYNTH
  // An invalid date always yields a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[23]) |-> (m_axis_tdata_o[22:0] == '0))
    else $error("date error with nonzero day difference");

  // The count stays inside the span of the supported calendar.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[22:0]) <= 23'sd3652059 &&
                         $signed(m_axis_tdata_o[22:0]) >= -23'sd3652059))
    else $error("day difference out of range");

  // The input only stalls when every stage is full and the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q && !m_axis_tready_i))
    else $error("input stalled with room in the pipeline");

  // A lane result that the merge stage takes shows up at the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> v3_q)
    else $error("lane result lost on its way to the output");
`endif

endmodule

/* hdl/ddays_lane.sv */
// One lane: turns a calendar date into an absolute day number and a validity flag.
// Two register stages; depends on ddays_pkg.
module ddays_lane
  import ddays_pkg::*;
(
  input  logic               clk_i,
  input  ddays_en_t          en_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output ddays_lane_t        res_o
);

  logic [YEAR_W-1:0]  year_q, prev_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   day_q;
  logic [PROD_W-1:0]  prod_y_q, prod_p_q;
  logic [DIFF_W-1:0]  p365_q;
  logic [YEAR_W-1:0]  prev_d;
  ddays_lane_t        res_d, res_q;

  assign prev_d = year_i - 14'd1;

  // Stage one: the constant multiplications.
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      year_q   <= year_i;
      prev_q   <= prev_d;
      month_q  <= month_i;
      day_q    <= day_i;
      prod_y_q <= PROD_W'(year_i) * PROD_W'(RECIP_100);
      prod_p_q <= PROD_W'(prev_d) * PROD_W'(RECIP_100);
      p365_q   <= DIFF_W'(prev_d) * DIFF_W'(365);
    end
  end

  logic [7:0]        q_y, q_p;
  logic              cent, leap;
  logic [8:0]        cum;
  logic [DAY_W-1:0]  mlen;
  logic [DIFF_W-1:0] sum;

  // Stage two: leap rule, validity and the day number sum.
  always_comb begin
    q_y  = prod_y_q[RECIP_SHIFT +: 8];
    q_p  = prod_p_q[RECIP_SHIFT +: 8];
    cent = (year_q == 14'({6'd0, q_y} * 14'd100));
    leap = (year_q[1:0] == 2'd0) && (!cent || (q_y[1:0] == 2'd0));
    mlen = month_len(month_q, leap);
    cum  = cum_days(month_q) + 9'((leap && (month_q > MONTH_FEB)) ? 1 : 0);
    sum  = p365_q + DIFF_W'(prev_q[YEAR_W-1:2]) - DIFF_W'(q_p) + DIFF_W'(q_p[7:2])
         + DIFF_W'(cum) + DIFF_W'(day_q);
    res_d.num = sum[NUM_W-1:0];
    res_d.ok  = (year_q != '0) && (year_q <= YEAR_MAX)
             && (month_q >= MONTH_JAN) && (month_q <= MONTH_DEC)
             && (day_q != '0) && (day_q <= mlen);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* hdl/ddays_merge.sv */
// Merge stage: subtracts the two lane day numbers and applies the end-day flag.
// Holds the output register; depends on ddays_pkg.
module ddays_merge
  import ddays_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_i,
  input  ddays_lane_t       first_i,
  input  ddays_lane_t       second_i,
  input  logic              inc_i,
  output logic [DIFF_W-1:0] diff_o,
  output logic              err_o
);

  logic [DIFF_W-1:0] diff_d, diff_q, adj;
  logic              err_d, err_q, fwd;

  always_comb begin
    fwd    = first_i.num <= second_i.num;
    // Going backward the magnitude grows by subtracting the flag.
    adj    = inc_i ? (fwd ? DIFF_W'(1) : '1) : '0;
    err_d  = !(first_i.ok && second_i.ok);
    diff_d = err_d ? '0
           : DIFF_W'(second_i.num) - DIFF_W'(first_i.num) + adj;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= diff_d;
      err_q  <= err_d;
    end
  end

  assign diff_o = diff_q;
  assign err_o  = err_q;

endmodule
